// ===== sv/icv_pkg.sv =====
// icv_pkg: shared types and constants for the interrupt collector with vector
// request and response payload structs, request kinds, level bit constants
// no dependencies
`default_nettype none

package icv_pkg;

   // request kinds carried in the req_type field
   typedef enum logic [1:0] {
      REQ_BUS_WRITE   = 2'd0,
      REQ_BUS_READ    = 2'd1,
      REQ_LINE_CHANGE = 2'd2,
      REQ_FC_UPDATE   = 2'd3
   } req_kind_type;

   // autovector action codes on the response
   typedef enum logic [1:0] {
      AV_NONE    = 2'd0,
      AV_ASSERT  = 2'd1,
      AV_RELEASE = 2'd2
   } av_action_type;

   // register select on the bus
   localparam logic REG_MASK_STATUS = 1'b0;
   localparam logic REG_VECTOR_BASE = 1'b1;

   // interrupt level bits
   localparam logic [15:0] LVL1_BIT = 16'h0002;
   localparam logic [15:0] LVL2_BIT = 16'h0004;
   localparam logic [15:0] LVL4_BIT = 16'h0010;
   localparam logic [15:0] NMI_BIT  = 16'h0080;

   // acknowledge function code
   localparam logic [2:0] IACK_FC = 3'd7;

   // level-1 device bits in priority order, highest first
   localparam logic [7:0] DEV_PRIO0 = 8'h80;
   localparam logic [7:0] DEV_PRIO1 = 8'h40;
   localparam logic [7:0] DEV_PRIO2 = 8'h10;
   localparam logic [7:0] DEV_PRIO3 = 8'h20;

   // status reset value and mask of the status-readable mask bits
   localparam logic [7:0] STATUS_RESET    = 8'h20;
   localparam logic [7:0] MASK_READ_BITS  = 8'h0f;
   localparam logic [7:0] VECTOR_BASE_MSK = 8'hfc;

   typedef struct packed {
      logic [1:0]  req_type;
      logic        reg_select;
      logic [7:0]  data_value;
      logic [15:0] irq_line_mask;
      logic [15:0] device_mask;
   } icv_req_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] irq_levels;
      logic        irq_update;
      logic [7:0]  vector;
      logic [1:0]  autovector_action;
   } icv_rsp_type;

endpackage

`default_nettype wire

// ===== sv/icv_core.sv =====
// icv_core: collector state and single-pass request evaluation
// holds mask, status, sources, pending levels and vector state
// depends on icv_pkg
`default_nettype none

module icv_core
   import icv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        fire,
   input  wire icv_req_type req,
   output icv_rsp_type      rsp
);

   logic [7:0]  level1_mask_ff,    level1_mask_in;
   logic [7:0]  level1_enable_ff,  level1_enable_in;
   logic [7:0]  level1_status_ff,  level1_status_in;
   logic [7:0]  vector_base_ff,    vector_base_in;
   logic [15:0] level2_sources_ff, level2_sources_in;
   logic [15:0] level4_sources_ff, level4_sources_in;
   logic [15:0] pending_ff,        pending_in;
   logic [2:0]  function_code_ff,  function_code_in;
   logic [15:0] acked_ff,          acked_in;
   logic [7:0]  cur_vector_ff,     cur_vector_in;

   logic        line_on;
   logic [7:0]  active_dev;
   logic [2:0]  fc;

   // next state and response for the request in hand
   always_comb begin
      level1_mask_in    = level1_mask_ff;
      level1_enable_in  = level1_enable_ff;
      level1_status_in  = level1_status_ff;
      vector_base_in    = vector_base_ff;
      level2_sources_in = level2_sources_ff;
      level4_sources_in = level4_sources_ff;
      pending_in        = pending_ff;
      function_code_in  = function_code_ff;
      acked_in          = acked_ff;
      cur_vector_in     = cur_vector_ff;

      line_on    = (req.data_value != 8'd0);
      active_dev = level1_status_ff & level1_enable_ff;
      fc         = req.data_value[2:0];

      rsp.read_data         = 8'd0;
      rsp.irq_update        = 1'b0;
      rsp.autovector_action = AV_NONE;

      case (req_kind_type'(req.req_type))
         REQ_BUS_WRITE: begin
            if (req.reg_select == REG_MASK_STATUS) begin
               level1_mask_in   = req.data_value;
               level1_enable_in = {req.data_value[2:0], req.data_value[3], 4'd0};
               if ((level1_status_ff & level1_enable_in) != 8'd0) begin
                  pending_in = pending_ff | LVL1_BIT;
               end else begin
                  pending_in = pending_ff & ~LVL1_BIT;
               end
               rsp.irq_update = 1'b1;
            end else begin
               vector_base_in = req.data_value & VECTOR_BASE_MSK;
            end
         end
         REQ_BUS_READ: begin
            if (req.reg_select == REG_MASK_STATUS) begin
               rsp.read_data = level1_status_ff | (level1_mask_ff & MASK_READ_BITS);
            end
         end
         REQ_LINE_CHANGE: begin
            if (req.irq_line_mask == LVL1_BIT) begin
               // level-1 device status bits, gated by enable
               if (line_on) begin
                  level1_status_in = level1_status_ff | req.device_mask[7:0];
               end else begin
                  level1_status_in = level1_status_ff & ~req.device_mask[7:0];
               end
               if ((level1_status_in & level1_enable_ff) != 8'd0) begin
                  pending_in = pending_ff | LVL1_BIT;
               end else begin
                  pending_in = pending_ff & ~LVL1_BIT;
               end
            end else if (req.irq_line_mask == LVL2_BIT) begin
               // level-2 wired or of device sources
               if (line_on) begin
                  level2_sources_in = level2_sources_ff | req.device_mask;
               end else begin
                  level2_sources_in = level2_sources_ff & ~req.device_mask;
               end
               if (level2_sources_in != 16'd0) begin
                  pending_in = pending_ff | LVL2_BIT;
               end else begin
                  pending_in = pending_ff & ~LVL2_BIT;
               end
            end else if (req.irq_line_mask == LVL4_BIT) begin
               // level-4 wired or of device sources
               if (line_on) begin
                  level4_sources_in = level4_sources_ff | req.device_mask;
               end else begin
                  level4_sources_in = level4_sources_ff & ~req.device_mask;
               end
               if (level4_sources_in != 16'd0) begin
                  pending_in = pending_ff | LVL4_BIT;
               end else begin
                  pending_in = pending_ff & ~LVL4_BIT;
               end
            end else begin
               // raw level bits
               if (line_on) begin
                  pending_in = pending_ff | req.irq_line_mask;
               end else begin
                  pending_in = pending_ff & ~req.irq_line_mask;
               end
            end
            rsp.irq_update = (pending_in != pending_ff);
         end
         REQ_FC_UPDATE: begin
            if (fc == IACK_FC) begin
               // acknowledge: nmi autovector first, then level-1 by priority
               if ((pending_ff & NMI_BIT) != 16'd0) begin
                  rsp.autovector_action = AV_ASSERT;
               end else if ((pending_ff & LVL1_BIT) != 16'd0) begin
                  if ((active_dev & DEV_PRIO0) != 8'd0) begin
                     cur_vector_in = vector_base_ff | 8'd0;
                  end else if ((active_dev & DEV_PRIO1) != 8'd0) begin
                     cur_vector_in = vector_base_ff | 8'd1;
                  end else if ((active_dev & DEV_PRIO2) != 8'd0) begin
                     cur_vector_in = vector_base_ff | 8'd2;
                  end else if ((active_dev & DEV_PRIO3) != 8'd0) begin
                     cur_vector_in = vector_base_ff | 8'd3;
                  end
               end
               acked_in = pending_ff;
            end else if (function_code_ff == IACK_FC) begin
               // leaving acknowledge releases an asserted nmi autovector
               if ((acked_ff & NMI_BIT) != 16'd0) begin
                  rsp.autovector_action = AV_RELEASE;
               end
               acked_in = pending_ff;
            end
            function_code_in = fc;
         end
         default: begin
         end
      endcase

      rsp.irq_levels = pending_in;
      rsp.vector     = cur_vector_in;
   end

   // state registers, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         level1_mask_ff    <= 8'd0;
         level1_enable_ff  <= 8'd0;
         level1_status_ff  <= STATUS_RESET;
         vector_base_ff    <= 8'd0;
         level2_sources_ff <= 16'd0;
         level4_sources_ff <= 16'd0;
         pending_ff        <= 16'd0;
         function_code_ff  <= 3'd0;
         acked_ff          <= 16'd0;
         cur_vector_ff     <= 8'd0;
      end else if (fire) begin
         level1_mask_ff    <= level1_mask_in;
         level1_enable_ff  <= level1_enable_in;
         level1_status_ff  <= level1_status_in;
         vector_base_ff    <= vector_base_in;
         level2_sources_ff <= level2_sources_in;
         level4_sources_ff <= level4_sources_in;
         pending_ff        <= pending_in;
         function_code_ff  <= function_code_in;
         acked_ff          <= acked_in;
         cur_vector_ff     <= cur_vector_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/interrupt_collector_with_vector_top.sv =====
// interrupt_collector_with_vector_top: top level of the interrupt collector
// input register, single-pass evaluation in icv_core, response register
// depends on icv_pkg and icv_core
//
//   channel  direction  ports                               payload
//   req      in         req_valid, req_ready, req_payload   icv_req_type
//   rsp      out        rsp_valid, rsp_ready, rsp_payload   icv_rsp_type
//
// one request per cycle sustained while the response side is ready; each request gives
// one response after acceptance (input register, then response register)
// synchronous active-high reset clears valid flags and collector state
// a stalled response holds the pipeline; the input register still takes a
// request while the response register is full but the evaluation stage is free

`default_nettype none

module interrupt_collector_with_vector_top
   import icv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire icv_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output icv_rsp_type      rsp_payload
);

   logic        in_valid_ff, in_valid_in;
   icv_req_type in_req_ff;
   logic        out_valid_ff, out_valid_in;
   icv_rsp_type out_rsp_ff;
   icv_rsp_type core_rsp;
   logic        advance;

   // handshake control
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready    = !in_valid_ff || advance;
      in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
   end

   // evaluation of the registered request
   icv_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .req   (in_req_ff),
      .rsp   (core_rsp)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_rsp_ff;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for interrupt_collector_with_vector_top
// queue-fed request driver, response monitor, in-bench predictor of the collector
// depends on icv_pkg and interrupt_collector_with_vector_top

module tb_top;
   import icv_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 1125;
   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned DRAIN_CYCLES    = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   icv_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   icv_rsp_type rsp_payload;

   // collector state as the bench sees it, at reset values
   logic [7:0]  col_mask   = 8'h00;
   logic [7:0]  col_enable = 8'h00;
   logic [7:0]  col_status = STATUS_RESET;
   logic [7:0]  col_vbase  = 8'h00;
   logic [15:0] col_l2src  = 16'h0000;
   logic [15:0] col_l4src  = 16'h0000;
   logic [15:0] col_levels = 16'h0000;
   logic [2:0]  col_fc     = 3'd0;
   logic [15:0] col_acked  = 16'h0000;
   logic [7:0]  col_vector = 8'h00;

   icv_req_type queued_requests[$];
   icv_rsp_type awaited_responses[$];

   int unsigned send_gap   = 0;
   int unsigned take_gap   = 0;
   int unsigned sent_count = 0;
   int unsigned got_count  = 0;
   int unsigned hold;
   int unsigned cycle_count = 0;
   int          errors = 0;
   icv_rsp_type want;

   interrupt_collector_with_vector_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] set_clr(input logic [15:0] v, input logic [15:0] bits,
                                           input logic on);
      return on ? (v | bits) : (v & ~bits);
   endfunction

   // one request through the collector: updates the state, returns the response
   function automatic icv_rsp_type collect_irq(input icv_req_type r);
      icv_rsp_type o;
      logic [15:0] prior;
      logic        asserted;
      logic [2:0]  code;
      logic [7:0]  live;
      o        = '0;
      asserted = (r.data_value != 8'd0);
      prior    = col_levels;
      case (req_kind_type'(r.req_type))
         REQ_BUS_WRITE: begin
            if (r.reg_select == REG_MASK_STATUS) begin
               col_mask   = r.data_value;
               col_enable = {col_mask[2:0], col_mask[3], 4'b0000};
               col_levels = set_clr(col_levels, LVL1_BIT, |(col_status & col_enable));
               o.irq_update = 1'b1;
            end else begin
               col_vbase = r.data_value & VECTOR_BASE_MSK;
            end
         end
         REQ_BUS_READ: begin
            if (r.reg_select == REG_MASK_STATUS)
               o.read_data = col_status | (col_mask & MASK_READ_BITS);
         end
         REQ_LINE_CHANGE: begin
            if (r.irq_line_mask == LVL1_BIT) begin
               // only the low byte of the device mask reaches the status
               col_status = asserted ? (col_status | r.device_mask[7:0])
                                     : (col_status & ~r.device_mask[7:0]);
               col_levels = set_clr(col_levels, LVL1_BIT, |(col_status & col_enable));
            end else if (r.irq_line_mask == LVL2_BIT) begin
               col_l2src  = set_clr(col_l2src, r.device_mask, asserted);
               col_levels = set_clr(col_levels, LVL2_BIT, col_l2src != 16'h0);
            end else if (r.irq_line_mask == LVL4_BIT) begin
               col_l4src  = set_clr(col_l4src, r.device_mask, asserted);
               col_levels = set_clr(col_levels, LVL4_BIT, col_l4src != 16'h0);
            end else begin
               col_levels = set_clr(col_levels, r.irq_line_mask, asserted);
            end
            o.irq_update = (prior != col_levels);
         end
         default: begin
            code = r.data_value[2:0];
            if (code == IACK_FC) begin
               // acknowledge: nmi first, else level-1 device by fixed priority
               live = col_status & col_enable;
               if (|(col_levels & NMI_BIT)) begin
                  o.autovector_action = AV_ASSERT;
               end else if (|(col_levels & LVL1_BIT)) begin
                  if (|(live & DEV_PRIO0))
                     col_vector = col_vbase | 8'd0;
                  else if (|(live & DEV_PRIO1))
                     col_vector = col_vbase | 8'd1;
                  else if (|(live & DEV_PRIO2))
                     col_vector = col_vbase | 8'd2;
                  else if (|(live & DEV_PRIO3))
                     col_vector = col_vbase | 8'd3;
               end
               col_acked = col_levels;
            end else if (col_fc == IACK_FC) begin
               if (|(col_acked & NMI_BIT))
                  o.autovector_action = AV_RELEASE;
               col_acked = col_levels;
            end
            col_fc = code;
         end
      endcase
      o.irq_levels = col_levels;
      o.vector     = col_vector;
      return o;
   endfunction

   function automatic icv_req_type make_req(input req_kind_type kind, input logic sel,
                                            input logic [7:0] data, input logic [15:0] lines,
                                            input logic [15:0] devs);
      icv_req_type r;
      r.req_type      = kind;
      r.reg_select    = sel;
      r.data_value    = data;
      r.irq_line_mask = lines;
      r.device_mask   = devs;
      return r;
   endfunction

   // random request, weighted towards line changes and acknowledge cycles
   function automatic icv_req_type random_request();
      icv_req_type r;
      int unsigned pick;
      int unsigned path;
      r.reg_select    = 1'($urandom);
      r.data_value    = 8'($urandom);
      r.irq_line_mask = 16'($urandom);
      r.device_mask   = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.req_type = REQ_BUS_WRITE;
      end else if (pick < 25) begin
         r.req_type = REQ_BUS_READ;
      end else if (pick < 70) begin
         r.req_type   = REQ_LINE_CHANGE;
         r.data_value = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
         path = $urandom_range(0, 9);
         if (path < 3) begin
            r.irq_line_mask = LVL1_BIT;
            if ($urandom_range(0, 3) != 0)
               r.device_mask = 16'($urandom) & 16'h00f0;
         end else if (path < 6) begin
            r.irq_line_mask = (path < 5) ? LVL2_BIT : LVL4_BIT;
            if ($urandom_range(0, 4) < 3)
               r.device_mask = 16'd1 << $urandom_range(0, 15);
         end else if (path < 8) begin
            r.irq_line_mask = NMI_BIT;
         end else if (path == 9) begin
            r.irq_line_mask = ($urandom_range(0, 3) == 0) ? 16'h0000
                                                          : 16'($urandom) & 16'($urandom);
         end
      end else begin
         r.req_type = REQ_FC_UPDATE;
         if ($urandom_range(0, 1) == 0)
            r.data_value[2:0] = IACK_FC;
      end
      return r;
   endfunction

   // cycles to wait before the next request or response; some stretches run flat out
   function automatic int unsigned draw_wait(input int unsigned n);
      return ((n / 40) % 4 == 1) ? 0 : $urandom_range(0, 6);
   endfunction

   task automatic check_field(input string what, input logic [15:0] exp_v,
                              input logic [15:0] got_v);
      if (got_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
         errors++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         // predict the request taken at this edge
         if (req_valid && req_ready)
            awaited_responses.push_back(collect_irq(req_payload));
         // present the next request once the current one is gone
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (queued_requests.size() != 0) begin
               req_payload <= queued_requests.pop_front();
               req_valid   <= 1'b1;
               send_gap    <= draw_wait(sent_count);
               sent_count  <= sent_count + 1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $display("%0t: unexpected response, expected none, got %h", $time, rsp_payload);
            errors++;
         end else begin
            want = awaited_responses.pop_front();
            check_field("read_data", 16'(want.read_data), 16'(rsp_payload.read_data));
            check_field("irq_levels", want.irq_levels, rsp_payload.irq_levels);
            check_field("irq_update", 16'(want.irq_update), 16'(rsp_payload.irq_update));
            check_field("vector", 16'(want.vector), 16'(rsp_payload.vector));
            check_field("autovector_action", 16'(want.autovector_action),
                        16'(rsp_payload.autovector_action));
         end
         hold = draw_wait(got_count);
         got_count <= got_count + 1;
         take_gap  <= hold;
         rsp_ready <= (hold == 0);
      end else if (take_gap != 0) begin
         take_gap  <= take_gap - 1;
         rsp_ready <= (take_gap == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // directed requests: register extremes, every path, acknowledge corners
      queued_requests.push_back(make_req(REQ_BUS_READ, REG_MASK_STATUS, 8'h00, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_BUS_READ, REG_VECTOR_BASE, 8'hff, 16'hffff,
                                         16'hffff));
      queued_requests.push_back(make_req(REQ_BUS_WRITE, REG_MASK_STATUS, 8'hff, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_BUS_READ, REG_MASK_STATUS, 8'h00, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_BUS_WRITE, REG_VECTOR_BASE, 8'hff, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h07, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h00, 16'h0, 16'h0));
      // wide device mask: only the low byte counts
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h01, LVL1_BIT, 16'hff80));
      // code taken from the low three bits only
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b1, 8'hff, 16'hffff, 16'hffff));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h07, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h00, LVL1_BIT, 16'h00ff));
      queued_requests.push_back(make_req(REQ_BUS_WRITE, REG_MASK_STATUS, 8'h00, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h80, LVL2_BIT, 16'hffff));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h00, LVL2_BIT, 16'h0001));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h00, LVL2_BIT, 16'hffff));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h01, LVL4_BIT, 16'h8000));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h01, NMI_BIT, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h07, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h03, 16'h0, 16'h0));
      // raw path with an empty selector changes nothing
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h01, 16'h0000, 16'h0));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h00, 16'hffff, 16'h0));
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'hff, 16'hffff, 16'h0));
      // level 1 pending with no enabled device: vector must hold
      queued_requests.push_back(make_req(REQ_LINE_CHANGE, 1'b0, 8'h00, NMI_BIT, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h07, 16'h0, 16'h0));
      queued_requests.push_back(make_req(REQ_FC_UPDATE, 1'b0, 8'h00, 16'h0, 16'h0));
      repeat (RANDOM_REQUESTS) queued_requests.push_back(random_request());

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // drain, then allow for the pipeline
      while (queued_requests.size() != 0 || req_valid || awaited_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
